FILE: rtl/mtef_pkg.sv
// ----------------------------------------------------------------------------
// mtef_pkg
// Shared codes for the track event framer: parse phases, byte roles and status byte values.
// ----------------------------------------------------------------------------
package mtef_pkg;

  typedef logic [2:0] phase_t;
  typedef logic [2:0] role_t;

  localparam phase_t PH_DELTA   = 3'd0;
  localparam phase_t PH_STATUS  = 3'd1;
  localparam phase_t PH_META    = 3'd2;
  localparam phase_t PH_COUNT   = 3'd3;
  localparam phase_t PH_PAYLOAD = 3'd4;
  localparam phase_t PH_CHANNEL = 3'd5;

  localparam role_t ROLE_DELTA   = 3'd0;
  localparam role_t ROLE_STATUS  = 3'd1;
  localparam role_t ROLE_META    = 3'd2;
  localparam role_t ROLE_COUNT   = 3'd3;
  localparam role_t ROLE_PAYLOAD = 3'd4;
  localparam role_t ROLE_CHANNEL = 3'd5;

  localparam logic [7:0] STATUS_SYSEX_END = 8'hF7;
  localparam logic [7:0] STATUS_META      = 8'hFF;
  localparam logic [3:0] NIB_SYSTEM       = 4'hF;
  localparam logic [3:0] NIB_PROG_CHANGE  = 4'hC;
  localparam logic [3:0] NIB_CHAN_PRESS   = 4'hD;

endpackage

FILE: rtl/midi_track_event_framer.sv
// ----------------------------------------------------------------------------
// midi_track_event_framer
// Results are registered: an input transfer's result is on the output in the next cycle.
// Throughput: one byte per cycle; the result register frees in the same cycle
// it is taken, so input ready is low only while a result waits unaccepted.
// Reset: synchronous, returns the parser to expect a delta time with cleared
// accumulator, held status and counters; output register empties.
// Frames track chunk bytes into events: delta time, status, meta type,
// count, payload and channel data bytes, one tagged result per byte.
// ----------------------------------------------------------------------------
module midi_track_event_framer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        track_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  byte_role,
  output logic        forward,
  output logic [31:0] delta_time,
  output logic        delta_done,
  output logic        event_last,
  output logic        bad_status,
  output logic [7:0]  event_status
);

  // parse state
  mtef_pkg::phase_t phase;
  logic [31:0]      delta_acc;
  logic [7:0]       held_status;
  logic [7:0]       payload_left;
  logic [1:0]       channel_left;

  mtef_pkg::phase_t phase_next;
  logic [31:0]      delta_acc_next;
  logic [7:0]       held_status_next;
  logic [7:0]       payload_left_next;
  logic [1:0]       channel_left_next;

  // state as seen by this byte after a track restart
  mtef_pkg::phase_t cur_phase;
  logic [31:0]      cur_acc;
  logic [7:0]       cur_status;
  logic [7:0]       cur_payload;
  logic [1:0]       cur_channel;
  logic [31:0]      acc_or;
  logic [7:0]       payload_dec;
  logic [1:0]       channel_dec;

  mtef_pkg::role_t  role_c;
  logic             fwd_c;
  logic [31:0]      dt_c;
  logic             ddone_c;
  logic             last_c;
  logic             bad_c;
  logic [7:0]       est_c;

  logic             in_xfer;

  assign in_ready = !out_valid || out_ready;
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    cur_phase   = track_start ? mtef_pkg::PH_DELTA : phase;
    cur_acc     = track_start ? 32'd0 : delta_acc;
    cur_status  = track_start ? 8'd0 : held_status;
    cur_payload = track_start ? 8'd0 : payload_left;
    cur_channel = track_start ? 2'd0 : channel_left;
    acc_or      = cur_acc | {25'd0, data_byte[6:0]};
    payload_dec = (cur_payload != 8'd0) ? cur_payload - 8'd1 : 8'd0;
    channel_dec = (cur_channel != 2'd0) ? cur_channel - 2'd1 : 2'd0;

    phase_next        = cur_phase;
    delta_acc_next    = cur_acc;
    held_status_next  = cur_status;
    payload_left_next = cur_payload;
    channel_left_next = cur_channel;

    role_c  = mtef_pkg::ROLE_DELTA;
    fwd_c   = 1'b0;
    dt_c    = 32'd0;
    ddone_c = 1'b0;
    last_c  = 1'b0;
    bad_c   = 1'b0;
    est_c   = 8'd0;

    unique case (cur_phase)
      mtef_pkg::PH_STATUS: begin
        role_c           = mtef_pkg::ROLE_STATUS;
        held_status_next = data_byte;
        est_c            = data_byte;
        if (!data_byte[7]) begin
          bad_c      = 1'b1;
          last_c     = 1'b1;
          phase_next = mtef_pkg::PH_DELTA;
        end else if (data_byte[7:4] == mtef_pkg::NIB_SYSTEM) begin
          fwd_c      = (data_byte != mtef_pkg::STATUS_SYSEX_END);
          phase_next = (data_byte == mtef_pkg::STATUS_META) ? mtef_pkg::PH_META
                                                            : mtef_pkg::PH_COUNT;
        end else begin
          fwd_c             = 1'b1;
          channel_left_next = (data_byte[7:4] == mtef_pkg::NIB_PROG_CHANGE ||
                               data_byte[7:4] == mtef_pkg::NIB_CHAN_PRESS) ? 2'd1 : 2'd2;
          phase_next        = mtef_pkg::PH_CHANNEL;
        end
      end
      mtef_pkg::PH_META: begin
        role_c     = mtef_pkg::ROLE_META;
        fwd_c      = 1'b1;
        est_c      = cur_status;
        phase_next = mtef_pkg::PH_COUNT;
      end
      mtef_pkg::PH_COUNT: begin
        role_c            = mtef_pkg::ROLE_COUNT;
        fwd_c             = 1'b1;
        est_c             = cur_status;
        payload_left_next = data_byte;
        if (data_byte == 8'd0) begin
          last_c     = 1'b1;
          phase_next = mtef_pkg::PH_DELTA;
        end else begin
          phase_next = mtef_pkg::PH_PAYLOAD;
        end
      end
      mtef_pkg::PH_PAYLOAD: begin
        role_c            = mtef_pkg::ROLE_PAYLOAD;
        fwd_c             = 1'b1;
        est_c             = cur_status;
        payload_left_next = payload_dec;
        if (payload_dec == 8'd0) begin
          last_c     = 1'b1;
          phase_next = mtef_pkg::PH_DELTA;
        end
      end
      mtef_pkg::PH_CHANNEL: begin
        role_c            = mtef_pkg::ROLE_CHANNEL;
        fwd_c             = 1'b1;
        est_c             = cur_status;
        channel_left_next = channel_dec;
        if (channel_dec == 2'd0) begin
          last_c     = 1'b1;
          phase_next = mtef_pkg::PH_DELTA;
        end
      end
      default: begin
        role_c = mtef_pkg::ROLE_DELTA;
        if (!data_byte[7]) begin
          dt_c           = acc_or;
          ddone_c        = 1'b1;
          delta_acc_next = 32'd0;
          phase_next     = mtef_pkg::PH_STATUS;
        end else begin
          delta_acc_next = {acc_or[24:0], 7'd0};
          phase_next     = mtef_pkg::PH_DELTA;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= mtef_pkg::PH_DELTA;
      delta_acc    <= 32'd0;
      held_status  <= 8'd0;
      payload_left <= 8'd0;
      channel_left <= 2'd0;
      out_valid    <= 1'b0;
    end else begin
      if (in_xfer) begin
        phase        <= phase_next;
        delta_acc    <= delta_acc_next;
        held_status  <= held_status_next;
        payload_left <= payload_left_next;
        channel_left <= channel_left_next;
        out_valid    <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      byte_role    <= role_c;
      forward      <= fwd_c;
      delta_time   <= dt_c;
      delta_done   <= ddone_c;
      event_last   <= last_c;
      bad_status   <= bad_c;
      event_status <= est_c;
    end
  end

  a_event_end_to_delta: assert property (@(posedge clk) disable iff (rst)
    in_xfer && last_c |=> phase == mtef_pkg::PH_DELTA)
    else $error("phase not back at delta after event end");

  a_bad_ends_event: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_status |-> event_last && !forward &&
      byte_role == mtef_pkg::ROLE_STATUS)
    else $error("bad status not framed as a closing status byte");

  a_delta_only_on_delta: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_role != mtef_pkg::ROLE_DELTA |-> !delta_done && delta_time == 32'd0)
    else $error("delta time reported on a non-delta byte");

  a_delta_then_status: assert property (@(posedge clk) disable iff (rst)
    in_xfer && ddone_c |=> phase == mtef_pkg::PH_STATUS)
    else $error("status not expected after last delta byte");

  a_phase_legal: assert property (@(posedge clk) disable iff (rst)
    phase == mtef_pkg::PH_DELTA || phase == mtef_pkg::PH_STATUS ||
    phase == mtef_pkg::PH_META || phase == mtef_pkg::PH_COUNT ||
    phase == mtef_pkg::PH_PAYLOAD || phase == mtef_pkg::PH_CHANNEL)
    else $error("phase holds an unused code");

endmodule
